[rtl/core/dphr_pkg.sv]
package dphr_pkg;

  localparam int unsigned MaxLen = 4096;
  localparam int unsigned IdxW   = $clog2(MaxLen);
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam int unsigned HashW  = 30;
  localparam int unsigned CntW   = $clog2(HashW);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HashW-1:0] HashP        = HashW'(1000000007);
  localparam logic [HashW-1:0] BaseOneReset = HashW'(31);
  localparam logic [HashW-1:0] BaseTwoReset = HashW'(37);
  localparam logic [7:0]       DigitOffset  = 8'd96;

  localparam logic [CfgIdxW-1:0] CfgBaseOne = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBaseTwo = CfgIdxW'(1);

  typedef enum logic {
    OpAppend = 1'b0,
    OpQuery  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StRdIssue,
    StRdFirst,
    StRdLow,
    StMulGo,
    StMulWait,
    StFinish
  } state_e;

  typedef struct packed {
    logic             start;
    logic [HashW-1:0] a;
    logic [HashW-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [HashW-1:0] result;
  } mm_rsp_t;

  // Both operands must already be below the modulus.
  function automatic logic [HashW-1:0] mod_add(logic [HashW-1:0] a, logic [HashW-1:0] b);
    logic [HashW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HashP}) begin
      s = s - {1'b0, HashP};
    end
    return s[HashW-1:0];
  endfunction

  function automatic logic [HashW-1:0] mod_sub(logic [HashW-1:0] a, logic [HashW-1:0] b);
    logic [HashW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, HashP} - {1'b0, b};
    end
    return s[HashW-1:0];
  endfunction

  // A value of the register width is below twice the modulus.
  function automatic logic [HashW-1:0] mod_reduce(logic [HashW-1:0] a);
    return (a >= HashP) ? (a - HashP) : a;
  endfunction

endpackage

[rtl/core/dphr_mulmod.sv]
module dphr_mulmod
  import dphr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic [HashW-1:0] a_q, a_d;
  logic [HashW-1:0] b_q, b_d;
  logic [HashW:0]   dbl;
  logic [HashW:0]   dbl_red;
  logic [HashW:0]   sum;
  logic [HashW:0]   sum_red;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;

    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, HashP}) ? (dbl - {1'b0, HashP}) : dbl;
    sum     = dbl_red + (b_q[HashW-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= {1'b0, HashP}) ? (sum - {1'b0, HashP}) : sum;

    if (busy_q) begin
      acc_d = sum_red[HashW-1:0];
      b_d   = {b_q[HashW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = CntW'(HashW - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

`ifndef SYNTHESIS
  a_acc_below_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> acc_q < HashP)
    else $error("accumulator left the residue range");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished multiply");
  a_start_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start && !busy_q |=> busy_q)
    else $error("start not taken");
`endif

endmodule

[rtl/core/double_prefix_hash_range_query.sv]
// Double polynomial hash modulo 1000000007 with substring queries. A command is taken when
// start is high and busy is low; its single result word appears on hash_one_o,
// hash_two_o and error_o, marked by done_o for exactly one cycle, and cannot be held off.
// Nearly all of the work from acceptance to the result strobe is done by one shared
// bit-serial modular multiplier (four products per append, two per query).
// A command that fails its range check (a bad query, or an append on a full store) is
// answered the cycle after acceptance and busy never rises. Configuration writes are
// taken only while busy is low.
module double_prefix_hash_range_query
  import dphr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic               start_new_i,
  input  logic [7:0]         ch_i,
  input  logic [IdxW-1:0]    left_index_i,
  input  logic [IdxW-1:0]    right_index_i,
  output logic               done_o,
  output logic [HashW-1:0]   hash_one_o,
  output logic [HashW-1:0]   hash_two_o,
  output logic               error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HashW-1:0]   cfg_data_i
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [HashW-1:0] base_one_q, base_two_q;
  logic [HashW-1:0] b1, b2;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  len_eff;
  logic [7:0]       ch_q, ch_d;
  logic [IdxW-1:0]  l_q, l_d;
  logic [IdxW-1:0]  r_q, r_d;
  logic [1:0]       k_q, k_d;

  logic [2*HashW-1:0] a_q, a_d;
  logic [2*HashW-1:0] p_q, p_d;
  logic [2*HashW-1:0] lo_q, lo_d;
  logic [HashW-1:0]   res_q [4];
  logic               res_we;

  logic               done_q, done_d;
  logic               err_q, err_d;
  logic [HashW-1:0]   h1_q, h1_d, h2_q, h2_d;

  logic [2*HashW-1:0] prefix_mem [MaxLen];
  logic [2*HashW-1:0] power_mem  [MaxLen+1];
  logic [IdxW-1:0]    pre_raddr;
  logic [LenW-1:0]    pow_raddr;
  logic [2*HashW-1:0] pre_rd_q, pow_rd_q;
  logic               mem_we;
  logic [2*HashW-1:0] pre_wdata, pow_wdata;

  logic [LenW-1:0]  span;
  logic [HashW-1:0] digit;
  logic             accept;
  logic             last_mul;
  logic [HashW-1:0] ap_h1, ap_h2, qr_h1, qr_h2;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  dphr_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign b1      = mod_reduce(base_one_q);
  assign b2      = mod_reduce(base_two_q);
  assign accept  = start && !busy;
  assign len_eff = (op_e'(op_i) == OpAppend && start_new_i) ? '0 : len_q;
  assign span    = {1'b0, r_q} - {1'b0, l_q} + LenW'(1);
  assign digit   = (ch_q >= DigitOffset) ? {22'b0, ch_q - DigitOffset}
                                         : (HashP - HashW'(DigitOffset) + {22'b0, ch_q});
  assign last_mul = (op_q == OpQuery) ? (k_q == 2'd1) : (k_q == 2'd3);

  assign ap_h1 = mod_add(res_q[0], digit);
  assign ap_h2 = mod_add(res_q[1], digit);
  assign qr_h1 = mod_sub(a_q[HashW-1:0], res_q[0]);
  assign qr_h2 = mod_sub(a_q[2*HashW-1:HashW], res_q[1]);

  assign pre_wdata = {ap_h2, ap_h1};
  assign pow_wdata = {res_q[3], res_q[2]};

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    len_d   = len_q;
    ch_d    = ch_q;
    l_d     = l_q;
    r_d     = r_q;
    k_d     = k_q;
    a_d     = a_q;
    p_d     = p_q;
    lo_d    = lo_q;
    done_d  = 1'b0;
    err_d   = err_q;
    h1_d    = h1_q;
    h2_d    = h2_q;
    res_we  = 1'b0;
    mem_we  = 1'b0;

    mm_req.start = 1'b0;
    mm_req.a     = '0;
    mm_req.b     = '0;

    pre_raddr = (op_q == OpQuery) ? r_q : (len_q[IdxW-1:0] - IdxW'(1));
    pow_raddr = (op_q == OpQuery) ? span : len_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d  = op_e'(op_i);
          ch_d  = ch_i;
          l_d   = left_index_i;
          r_d   = right_index_i;
          len_d = len_eff;
          k_d   = '0;
          if (op_e'(op_i) == OpAppend && len_eff == LenW'(MaxLen)) begin
            done_d = 1'b1;
            err_d  = 1'b1;
            h1_d   = '0;
            h2_d   = '0;
          end else if (op_e'(op_i) == OpQuery &&
                       (left_index_i > right_index_i ||
                        {1'b0, right_index_i} >= len_q)) begin
            done_d = 1'b1;
            err_d  = 1'b1;
            h1_d   = '0;
            h2_d   = '0;
          end else begin
            state_d = StRdIssue;
          end
        end
      end
      StRdIssue: begin
        state_d = StRdFirst;
      end
      StRdFirst: begin
        pre_raddr = l_q - IdxW'(1);
        if (op_q == OpAppend && len_q == '0) begin
          a_d = '0;
          p_d = {HashW'(1), HashW'(1)};
          state_d = StMulGo;
        end else begin
          a_d = pre_rd_q;
          p_d = pow_rd_q;
          state_d = (op_q == OpQuery) ? StRdLow : StMulGo;
        end
      end
      StRdLow: begin
        lo_d    = (l_q == '0) ? '0 : pre_rd_q;
        state_d = StMulGo;
      end
      StMulGo: begin
        mm_req.start = 1'b1;
        if (op_q == OpQuery) begin
          mm_req.a = k_q[0] ? lo_q[2*HashW-1:HashW] : lo_q[HashW-1:0];
          mm_req.b = k_q[0] ? p_q[2*HashW-1:HashW] : p_q[HashW-1:0];
        end else begin
          if (k_q[1]) begin
            mm_req.a = k_q[0] ? p_q[2*HashW-1:HashW] : p_q[HashW-1:0];
          end else begin
            mm_req.a = k_q[0] ? a_q[2*HashW-1:HashW] : a_q[HashW-1:0];
          end
          mm_req.b = k_q[0] ? b2 : b1;
        end
        state_d = StMulWait;
      end
      StMulWait: begin
        if (mm_rsp.done) begin
          res_we = 1'b1;
          if (last_mul) begin
            state_d = StFinish;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = StMulGo;
          end
        end
      end
      StFinish: begin
        done_d  = 1'b1;
        err_d   = 1'b0;
        state_d = StIdle;
        if (op_q == OpAppend) begin
          mem_we = 1'b1;
          len_d  = len_q + LenW'(1);
          h1_d   = ap_h1;
          h2_d   = ap_h2;
        end else begin
          h1_d = qr_h1;
          h2_d = qr_h2;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      len_q      <= '0;
      done_q     <= 1'b0;
      base_one_q <= BaseOneReset;
      base_two_q <= BaseTwoReset;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgBaseOne: base_one_q <= cfg_data_i;
          CfgBaseTwo: base_two_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    ch_q <= ch_d;
    l_q  <= l_d;
    r_q  <= r_d;
    k_q  <= k_d;
    a_q  <= a_d;
    p_q  <= p_d;
    lo_q <= lo_d;
    err_q <= err_d;
    h1_q <= h1_d;
    h2_q <= h2_d;
    if (res_we) begin
      res_q[k_q] <= mm_rsp.result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prefix_mem[len_q[IdxW-1:0]] <= pre_wdata;
    end
    pre_rd_q <= prefix_mem[pre_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      power_mem[len_q + LenW'(1)] <= pow_wdata;
    end
    pow_rd_q <= power_mem[pow_raddr];
  end

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign hash_one_o  = h1_q;
  assign hash_two_o  = h2_q;
  assign error_o     = err_q;

`ifndef SYNTHESIS
  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxLen))
    else $error("string length beyond the store");
  a_error_zero_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && err_q |-> h1_q == '0 && h2_q == '0)
    else $error("error word carries a hash");
  a_mul_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.busy |-> state_q == StMulWait)
    else $error("multiplier running outside its wait state");
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish && op_q == OpAppend |=> len_q == $past(len_q) + LenW'(1))
    else $error("append did not extend the string");
`endif

endmodule
